### rtl/str_pkg.sv
// Shared types and constants for the stepper trapezoid ramp generator.
package str_pkg;

    // Dividend, divisor and period-denominator widths of the shared divider path
    localparam int NUM_W = 48;
    localparam int DIV_W = 32;
    localparam int DEN_W = 50;
    localparam int PROD_W = 49;

    // Period loaded for a move of one single step
    localparam logic [15:0] SINGLE_DLY = 16'd20;

    typedef enum logic [1:0] {
        PH_STOP  = 2'd0,
        PH_ACCEL = 2'd1,
        PH_RUN   = 2'd2,
        PH_DECEL = 2'd3
    } phase_t;

    // Datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_SINGLE,
        OP_DEN_SPD,
        OP_DIV_DEN,
        OP_SET_FLOOR,
        OP_DIV_SPAN_ACC,
        OP_SET_MAXLIM,
        OP_MUL_MAG,
        OP_DIV_PROD,
        OP_SET_ACCLIM,
        OP_BRAKE_ACC,
        OP_DIV_SPAN_DEC,
        OP_BRAKE_DEC,
        OP_T_STEP,
        OP_MUL_ACC,
        OP_DEN_ACC,
        OP_ACC_END,
        OP_RUN_END,
        OP_DIV_FLOOR1,
        OP_MUL_DEC,
        OP_DEN_DEC,
        OP_DEC_END
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic   func;
        logic   mag_zero;
        logic   mag_one;
        phase_t phase_eff;
        logic   den_ok;
        logic   acc_le_max;
        logic   div_busy;
    } dp_stat_t;

endpackage

### rtl/str_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module str_div import str_pkg::*; #(
    parameter int NW = 48,
    parameter int DW = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          busy,
    output logic [NW-1:0] quotient
);

    localparam int CW = $clog2(NW + 1);

    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] dvs_reg;
    logic [DW:0]   rem_sh;

    // Shift in the next dividend bit and subtract when it fits
    always_comb begin
        rem_sh = {rem_reg, quo_reg[NW-1]};
        if (rem_sh >= {1'b0, dvs_reg}) begin
            rem_next = DW'(rem_sh - {1'b0, dvs_reg});
            quo_next = {quo_reg[NW-2:0], 1'b1};
        end else begin
            rem_next = rem_sh[DW-1:0];
            quo_next = {quo_reg[NW-2:0], 1'b0};
        end
    end

    // Count iterations
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NW);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Hold operands and partial results
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

### rtl/str_dp.sv
// Ramp datapath: move state, step counters, multiplier and shared divider.
module str_dp import str_pkg::*; #(
    parameter int TIMER_HZ = 1000000,
    parameter int START_HZ = 20
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ctrl_cmd_t          cmd,
    output dp_stat_t           stat,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               s_func,
    input  logic signed [31:0] s_step_total,
    input  logic [15:0]        s_accel_rate,
    input  logic [15:0]        s_decel_rate,
    input  logic [16:0]        s_top_speed,
    output logic               m_step_pulse,
    output logic               m_direction,
    output logic [15:0]        m_period_reload,
    output logic               m_busy_res,
    output logic signed [31:0] m_position
);

    localparam int CAP_RAW = TIMER_HZ / START_HZ - 1;
    localparam int CAP_INT = (CAP_RAW > 65535) ? 65535 : ((CAP_RAW < 0) ? 0 : CAP_RAW);
    localparam logic [15:0] CAP_DLY = 16'(CAP_INT);
    localparam logic [NUM_W-1:0] TMR_NUM = NUM_W'(TIMER_HZ);
    localparam logic signed [DEN_W-1:0] TMR_DEN = DEN_W'(TIMER_HZ);
    localparam logic [16:0] START_SPD = 17'(START_HZ);

    // Move state
    logic        oe_reg;
    phase_t      phase_reg;
    logic [15:0] cur_delay_reg, floor_delay_reg;
    logic [31:0] brake_start_reg, bsn_reg, ramp_count_reg, brake_count_reg;
    logic [31:0] steps_done_reg, abs_pos_reg;
    logic        move_dir_reg, running_reg;
    logic [15:0] up_rate_reg, down_rate_reg;

    // Working registers
    logic                     func_reg, pulse_reg;
    logic [15:0]              reload_reg;
    logic [31:0]              mag_reg, acc_lim_reg;
    logic [16:0]              spd_reg;
    logic [17:0]              max_lim_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [DEN_W-1:0]  den_reg;

    // Divider hookup
    logic             div_start, div_busy;
    logic [NUM_W-1:0] div_num, div_quo;
    logic [DIV_W-1:0] div_dvs;

    logic [31:0]             st_u, mag_in;
    logic [16:0]             span;
    logic [15:0]             acc_d, dec_d, dly, nxt_acc;
    logic [16:0]             rate_sum;
    logic                    den_pos, den_ok, cnt_ge;
    logic [NUM_W-1:0]        quo_m1, md_prod, bc_prod;
    logic signed [33:0]      dval_raw, dval, bsum;
    phase_t                  phase_eff;

    str_div #(.NW(NUM_W), .DW(DIV_W)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // Derive command operands and period conversion
    always_comb begin
        st_u     = s_step_total;
        mag_in   = st_u[31] ? (32'd0 - st_u) : st_u;
        span     = (spd_reg > START_SPD) ? (spd_reg - START_SPD) : 17'd0;
        acc_d    = (up_rate_reg != 16'd0) ? up_rate_reg : 16'd1;
        dec_d    = (down_rate_reg != 16'd0) ? down_rate_reg : 16'd1;
        rate_sum = {1'b0, up_rate_reg} + {1'b0, down_rate_reg};
        md_prod  = NUM_W'(mag_reg) * NUM_W'(down_rate_reg);
        bc_prod  = NUM_W'(brake_count_reg) * NUM_W'(down_rate_reg);
        den_pos  = !den_reg[DEN_W-1] && (den_reg != '0);
        den_ok   = den_pos && (den_reg <= TMR_DEN);
        quo_m1   = div_quo - NUM_W'(1);
        if (!den_pos) begin
            dly = CAP_DLY;
        end else if (!den_ok) begin
            dly = 16'd0;
        end else if (quo_m1 > NUM_W'(CAP_DLY)) begin
            dly = CAP_DLY;
        end else begin
            dly = quo_m1[15:0];
        end
        nxt_acc   = dly;
        cnt_ge    = steps_done_reg >= brake_start_reg;
        phase_eff = oe_reg ? phase_reg : PH_STOP;
        if (cmd.op == OP_BRAKE_ACC) begin
            dval_raw = $signed({2'b00, acc_lim_reg}) - $signed({2'b00, mag_reg});
        end else begin
            dval_raw = -$signed(34'(div_quo[17:0])) - 34'sd1;
        end
        dval = (dval_raw == 34'sd0) ? -34'sd1 : dval_raw;
        bsum = $signed({2'b00, mag_reg}) + dval;
    end

    // Select divider operands
    always_comb begin
        div_start = 1'b1;
        div_num   = TMR_NUM;
        div_dvs   = den_reg[DIV_W-1:0];
        case (cmd.op)
            OP_DIV_DEN: begin
                div_num = TMR_NUM;
                div_dvs = den_reg[DIV_W-1:0];
            end
            OP_DIV_SPAN_ACC: begin
                div_num = NUM_W'(span);
                div_dvs = DIV_W'(acc_d);
            end
            OP_DIV_PROD: begin
                div_num = prod_reg[NUM_W-1:0];
                div_dvs = (rate_sum != 17'd0) ? DIV_W'(rate_sum) : DIV_W'(1);
            end
            OP_DIV_SPAN_DEC: begin
                div_num = NUM_W'(span);
                div_dvs = DIV_W'(dec_d);
            end
            OP_DIV_FLOOR1: begin
                div_num = TMR_NUM;
                div_dvs = DIV_W'(floor_delay_reg) + DIV_W'(1);
            end
            default: div_start = 1'b0;
        endcase
    end

    // Working registers
    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                func_reg   <= s_func;
                reload_reg <= cur_delay_reg;
                pulse_reg  <= 1'b0;
                mag_reg    <= mag_in;
                spd_reg    <= s_top_speed;
            end
            OP_DEN_SPD:    den_reg <= $signed(DEN_W'(spd_reg));
            OP_SET_MAXLIM: max_lim_reg <= {1'b0, div_quo[16:0]} + 18'd1;
            OP_MUL_MAG:    prod_reg <= $signed({1'b0, md_prod});
            OP_SET_ACCLIM: acc_lim_reg <= (div_quo >= NUM_W'(2)) ? quo_m1[31:0] : 32'd1;
            OP_T_STEP:     pulse_reg <= (phase_eff != PH_STOP);
            OP_MUL_ACC:    prod_reg <= $signed({1'b0, up_rate_reg}) * $signed(ramp_count_reg);
            OP_DEN_ACC:    den_reg <= $signed(DEN_W'(START_HZ)) + DEN_W'(prod_reg);
            OP_MUL_DEC:    prod_reg <= $signed({1'b0, bc_prod});
            OP_DEN_DEC:    den_reg <= $signed({2'b00, div_quo}) - DEN_W'(prod_reg);
            default: ;
        endcase
    end

    // Move state updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oe_reg          <= 1'b1;
            phase_reg       <= PH_STOP;
            cur_delay_reg   <= '0;
            floor_delay_reg <= '0;
            brake_start_reg <= '0;
            bsn_reg         <= '0;
            ramp_count_reg  <= '0;
            brake_count_reg <= '0;
            steps_done_reg  <= '0;
            abs_pos_reg     <= '0;
            move_dir_reg    <= 1'b1;
            running_reg     <= 1'b0;
            up_rate_reg     <= '0;
            down_rate_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                oe_reg <= cfg_wr_data;
            end
            case (cmd.op)
                OP_LOAD: begin
                    if (!s_func) begin
                        up_rate_reg   <= s_accel_rate;
                        down_rate_reg <= s_decel_rate;
                        move_dir_reg  <= ~s_step_total[31];
                    end
                end
                OP_SINGLE: begin
                    ramp_count_reg <= '1;
                    phase_reg      <= PH_DECEL;
                    cur_delay_reg  <= SINGLE_DLY;
                    running_reg    <= 1'b1;
                end
                OP_SET_FLOOR: floor_delay_reg <= dly;
                OP_BRAKE_ACC, OP_BRAKE_DEC: begin
                    bsn_reg         <= dval[31:0];
                    brake_start_reg <= bsum[33] ? 32'd0 : bsum[31:0];
                    if (CAP_DLY <= floor_delay_reg) begin
                        cur_delay_reg <= floor_delay_reg;
                        phase_reg     <= PH_RUN;
                    end else begin
                        cur_delay_reg <= CAP_DLY;
                        phase_reg     <= PH_ACCEL;
                    end
                    ramp_count_reg  <= '0;
                    brake_count_reg <= '0;
                    running_reg     <= 1'b1;
                end
                OP_T_STEP: begin
                    phase_reg <= phase_eff;
                    if (phase_eff == PH_STOP) begin
                        steps_done_reg <= '0;
                        running_reg    <= 1'b0;
                    end else begin
                        abs_pos_reg    <= abs_pos_reg + (move_dir_reg ? 32'd1 : '1);
                        steps_done_reg <= steps_done_reg + 32'd1;
                        if (phase_eff != PH_RUN) begin
                            ramp_count_reg <= ramp_count_reg + 32'd1;
                        end
                        if (phase_eff == PH_DECEL) begin
                            brake_count_reg <= brake_count_reg + 32'd1;
                        end
                    end
                end
                OP_ACC_END: begin
                    if (cnt_ge) begin
                        cur_delay_reg  <= nxt_acc;
                        ramp_count_reg <= bsn_reg;
                        phase_reg      <= PH_DECEL;
                    end else if (nxt_acc <= floor_delay_reg) begin
                        cur_delay_reg <= floor_delay_reg;
                        phase_reg     <= PH_RUN;
                    end else begin
                        cur_delay_reg <= nxt_acc;
                    end
                end
                OP_RUN_END: begin
                    cur_delay_reg <= floor_delay_reg;
                    if (cnt_ge) begin
                        ramp_count_reg <= bsn_reg;
                        phase_reg      <= PH_DECEL;
                    end
                end
                OP_DEC_END: begin
                    cur_delay_reg <= dly;
                    if (!ramp_count_reg[31]) begin
                        phase_reg     <= PH_STOP;
                        up_rate_reg   <= '0;
                        down_rate_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Report status to the controller
    always_comb begin
        stat.func       = func_reg;
        stat.mag_zero   = (mag_reg == 32'd0);
        stat.mag_one    = (mag_reg == 32'd1);
        stat.phase_eff  = phase_eff;
        stat.den_ok     = den_ok;
        stat.acc_le_max = (acc_lim_reg <= 32'(max_lim_reg));
        stat.div_busy   = div_busy;
    end

    assign m_step_pulse    = pulse_reg;
    assign m_direction     = move_dir_reg;
    assign m_period_reload = reload_reg;
    assign m_busy_res      = running_reg;
    assign m_position      = $signed(abs_pos_reg);

endmodule

### rtl/str_ctrl.sv
// Ramp controller: sequences the datapath through one item at a time.
module str_ctrl import str_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_DLY_START,
        ST_WAIT,
        ST_C_FLOOR,
        ST_C_DIV_ACC,
        ST_C_MAXLIM,
        ST_C_MUL,
        ST_C_DIV_Q,
        ST_C_ACCLIM,
        ST_C_CMP,
        ST_C_BRAKE_DEC,
        ST_T_ACC_MUL,
        ST_T_ACC_DEN,
        ST_T_ACC_END,
        ST_T_RUN_END,
        ST_T_DEC_DIV,
        ST_T_DEC_MUL,
        ST_T_DEC_DEN,
        ST_T_DEC_END,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;
    state_t ret_reg, ret_next;

    // Decode next state and datapath operation
    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd.op     = OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (!stat.func) begin
                    if (stat.mag_zero) begin
                        state_next = ST_DONE;
                    end else if (stat.mag_one) begin
                        cmd.op     = OP_SINGLE;
                        state_next = ST_DONE;
                    end else begin
                        cmd.op     = OP_DEN_SPD;
                        ret_next   = ST_C_FLOOR;
                        state_next = ST_DLY_START;
                    end
                end else begin
                    cmd.op = OP_T_STEP;
                    case (stat.phase_eff)
                        PH_ACCEL: state_next = ST_T_ACC_MUL;
                        PH_RUN:   state_next = ST_T_RUN_END;
                        PH_DECEL: state_next = ST_T_DEC_DIV;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_DLY_START: begin
                if (stat.den_ok) begin
                    cmd.op     = OP_DIV_DEN;
                    state_next = ST_WAIT;
                end else begin
                    state_next = ret_reg;
                end
            end
            ST_WAIT: begin
                if (!stat.div_busy) begin
                    state_next = ret_reg;
                end
            end
            ST_C_FLOOR: begin
                cmd.op     = OP_SET_FLOOR;
                state_next = ST_C_DIV_ACC;
            end
            ST_C_DIV_ACC: begin
                cmd.op     = OP_DIV_SPAN_ACC;
                ret_next   = ST_C_MAXLIM;
                state_next = ST_WAIT;
            end
            ST_C_MAXLIM: begin
                cmd.op     = OP_SET_MAXLIM;
                state_next = ST_C_MUL;
            end
            ST_C_MUL: begin
                cmd.op     = OP_MUL_MAG;
                state_next = ST_C_DIV_Q;
            end
            ST_C_DIV_Q: begin
                cmd.op     = OP_DIV_PROD;
                ret_next   = ST_C_ACCLIM;
                state_next = ST_WAIT;
            end
            ST_C_ACCLIM: begin
                cmd.op     = OP_SET_ACCLIM;
                state_next = ST_C_CMP;
            end
            ST_C_CMP: begin
                if (stat.acc_le_max) begin
                    cmd.op     = OP_BRAKE_ACC;
                    state_next = ST_DONE;
                end else begin
                    cmd.op     = OP_DIV_SPAN_DEC;
                    ret_next   = ST_C_BRAKE_DEC;
                    state_next = ST_WAIT;
                end
            end
            ST_C_BRAKE_DEC: begin
                cmd.op     = OP_BRAKE_DEC;
                state_next = ST_DONE;
            end
            ST_T_ACC_MUL: begin
                cmd.op     = OP_MUL_ACC;
                state_next = ST_T_ACC_DEN;
            end
            ST_T_ACC_DEN: begin
                cmd.op     = OP_DEN_ACC;
                ret_next   = ST_T_ACC_END;
                state_next = ST_DLY_START;
            end
            ST_T_ACC_END: begin
                cmd.op     = OP_ACC_END;
                state_next = ST_DONE;
            end
            ST_T_RUN_END: begin
                cmd.op     = OP_RUN_END;
                state_next = ST_DONE;
            end
            ST_T_DEC_DIV: begin
                cmd.op     = OP_DIV_FLOOR1;
                ret_next   = ST_T_DEC_MUL;
                state_next = ST_WAIT;
            end
            ST_T_DEC_MUL: begin
                cmd.op     = OP_MUL_DEC;
                state_next = ST_T_DEC_DEN;
            end
            ST_T_DEC_DEN: begin
                cmd.op     = OP_DEN_DEC;
                ret_next   = ST_T_DEC_END;
                state_next = ST_DLY_START;
            end
            ST_T_DEC_END: begin
                cmd.op     = OP_DEC_END;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Hold state and the result-valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            m_valid   <= 1'b0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            m_valid   <= (state_next == ST_DONE);
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

### rtl/stepper_trapezoid_ramp.sv
// Stepper trapezoid ramp generator, top level.
//
// Takes one item at a time: a start-move command (s_func = 0) or a timer
// tick (s_func = 1), and returns one result item each. A move command plans
// the ramp with up to four passes through the shared radix-2 divider; the
// period division is skipped when the top speed is zero, and a single-step
// or zero-step command uses no division. A tick uses no division in the
// stop and cruise phases, one while accelerating (skipped when the new
// rate is zero, negative or above the timer clock) and one or two while
// decelerating.
// s_ready is low from acceptance until the result item is taken.
// output_enable is written through cfg_wr_en / cfg_wr_data and resets to 1.
module stepper_trapezoid_ramp import str_pkg::*; #(
    parameter int TIMER_HZ = 1000000,
    parameter int START_HZ = 20
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic signed [31:0] s_step_total,
    input  logic [15:0]        s_accel_rate,
    input  logic [15:0]        s_decel_rate,
    input  logic [16:0]        s_top_speed,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_step_pulse,
    output logic               m_direction,
    output logic [15:0]        m_period_reload,
    output logic               m_busy_res,
    output logic signed [31:0] m_position
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    str_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    str_dp #(.TIMER_HZ(TIMER_HZ), .START_HZ(START_HZ)) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_func          (s_func),
        .s_step_total    (s_step_total),
        .s_accel_rate    (s_accel_rate),
        .s_decel_rate    (s_decel_rate),
        .s_top_speed     (s_top_speed),
        .m_step_pulse    (m_step_pulse),
        .m_direction     (m_direction),
        .m_period_reload (m_period_reload),
        .m_busy_res      (m_busy_res),
        .m_position      (m_position)
    );

endmodule

### rtl/str_checker.sv
// Port-level checks for the stepper ramp generator, bound to the top level.
module str_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic               m_step_pulse,
    input logic               m_busy_res,
    input logic signed [31:0] m_position
);

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_position))
        else $error("stalled result item changed");

    // Take no item while a result waits
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> !m_valid)
        else $error("item accepted while result pending");

    // Drop valid after the result is taken
    a_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> !m_valid)
        else $error("result item repeated");

    // A step pulse only comes during a move
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_step_pulse |-> m_busy_res)
        else $error("step pulse while not busy");

endmodule

bind stepper_trapezoid_ramp str_checker u_str_checker (.*);
